[design/psd_pkg.sv]
// Package for the PES stream deframer: parse phases, byte labels, stream id codes
// and the labelled result record shared by the parser and the top level.
// No dependencies.
package psd_pkg;

	localparam int MAX_STUFFING_DEFAULT = 32;

	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 17;
	localparam int PLEN_W   = 16;

	typedef enum logic [3:0] {
		PH_SEARCH    = 4'd0,
		PH_PACK      = 4'd1,
		PH_PACKSTUFF = 4'd2,
		PH_SYS       = 4'd3,
		PH_PES       = 4'd4,
		PH_M2SKIP    = 4'd5,
		PH_M2LEN     = 4'd6,
		PH_M1SKIP    = 4'd7,
		PH_M1FLAGS   = 4'd8,
		PH_DONE      = 4'd9,
		PH_REJECT    = 4'd10
	} psd_phase_t;

	typedef enum logic [1:0] {
		KIND_SKIP    = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_PAYLOAD = 2'd2
	} psd_kind_t;

	localparam logic [7:0] ID_REJECT_MAX = 8'hB8;
	localparam logic [7:0] ID_PACK       = 8'hBA;
	localparam logic [7:0] ID_SYSTEM     = 8'hBB;
	localparam logic [7:0] ID_PRIVATE1   = 8'hBD;
	localparam logic [7:0] ID_PADDING    = 8'hBE;
	localparam logic [7:0] ID_PRIVATE2   = 8'hBF;
	localparam logic [7:0] ID_AV_FIRST   = 8'hC0;
	localparam logic [7:0] ID_AV_LAST    = 8'hEF;

	localparam logic [1:0] TOP_STUFF = 2'b11;
	localparam logic [1:0] TOP_MPEG2 = 2'b10;
	localparam logic [1:0] TOP_MPEG1 = 2'b01;

	localparam logic [1:0] M1_PTS_DTS = 2'b11;
	localparam logic [1:0] M1_PTS     = 2'b10;

	typedef struct packed {
		logic [7:0] out_byte;
		psd_kind_t  byte_kind;
		logic [7:0] pkt_id;
		logic       packet_first;
		logic       packet_last;
		logic       packet_rejected;
		logic       is_mpeg2;
	} psd_result_t;

endpackage

[design/pes_stream_deframer_unit.sv]
// PES stream deframer top level: input stage, parser and output register.
// Labels pass the input stage and output register and trail the stream by three bytes.
// One byte per cycle unless output stalls; the parser updates state in one registered step.
// The first three bytes after reset only fill the look-behind window and give no output.
// Reset (arst_n low) empties the window, returns to start code search and sets MPEG-2 mode.
// Depends on psd_pkg and psd_parser.
module pes_stream_deframer_unit #(
	parameter int MAX_STUFFING = psd_pkg::MAX_STUFFING_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] pkt_id
	output logic [4:0]  m_tuser,   // [1:0] byte_kind, [2] packet_first,
	                               // [3] packet_rejected, [4] is_mpeg2
	output logic        m_tlast    // packet_last
);

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 out_valid_q;
	psd_pkg::psd_result_t out_res_q;
	psd_pkg::psd_result_t res;
	logic                 emit;
	logic                 move;

	psd_parser #(
		.MAX_STUFFING(MAX_STUFFING)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (move),
		.data_byte (data_s1),
		.emit      (emit),
		.res       (res)
	);

	assign move     = valid_s1 && (!emit || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (move && emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			data_s1 <= s_tdata;
		if (move && emit)
			out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.pkt_id, out_res_q.out_byte};
	assign m_tuser  = {out_res_q.is_mpeg2, out_res_q.packet_rejected,
		out_res_q.packet_first, out_res_q.byte_kind};
	assign m_tlast  = out_res_q.packet_last;

	a_reject_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res_q.packet_rejected |-> out_res_q.packet_last)
		else $error("rejected label without packet end");

	a_first_is_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res_q.packet_first |->
		out_res_q.byte_kind == psd_pkg::KIND_HEADER)
		else $error("packet start not labelled as header");

	a_skip_has_no_packet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res_q.byte_kind == psd_pkg::KIND_SKIP |->
		out_res_q.pkt_id == 8'h00 && !out_res_q.packet_last)
		else $error("skipped byte carries packet fields");

	a_stalled_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !move |=> valid_s1 && $stable(data_s1))
		else $error("input stage lost a byte under stall");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_res_q))
		else $error("output register overwritten before transaction");

endmodule

[design/psd_parser.sv]
// Start code search, header parse and payload count for the PES stream deframer.
// Holds the three-byte look-behind window and all packet state; one byte per step.
// Depends on psd_pkg.
module psd_parser #(
	parameter int MAX_STUFFING = psd_pkg::MAX_STUFFING_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                data_byte,
	output logic                      emit,
	output psd_pkg::psd_result_t      res
);

	localparam int STUFF_W = $clog2(MAX_STUFFING + 1);
	localparam int OW = psd_pkg::OFFSET_W;

	logic [23:0]                   window_q, window_n;
	logic [1:0]                    fill_q, fill_n;
	psd_pkg::psd_phase_t           phase_q, phase_n;
	logic [OW-1:0]                 offset_q, offset_n;
	logic [OW-1:0]                 hdr_len_q, hdr_len_n;
	logic [psd_pkg::PLEN_W-1:0]    pkt_len_q, pkt_len_n;
	logic [7:0]                    id_q, id_n;
	logic [7:0]                    len_hi_q, len_hi_n;
	logic [STUFF_W-1:0]            stuff_q, stuff_n;
	logic                          mpeg2_q, mpeg2_n;

	function automatic logic [OW-1:0] mpeg1_hdr_len(input logic [OW-1:0] pos,
		input logic [7:0] b);
		logic [OW-1:0] len;
		case (b[5:4])
			psd_pkg::M1_PTS_DTS: len = pos + OW'(10);
			psd_pkg::M1_PTS:     len = pos + OW'(5);
			default:             len = pos + OW'(1);
		endcase
		return len;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			fill_q    <= '0;
			phase_q   <= psd_pkg::PH_SEARCH;
			offset_q  <= '0;
			hdr_len_q <= '0;
			pkt_len_q <= '0;
			id_q      <= '0;
			len_hi_q  <= '0;
			stuff_q   <= '0;
			mpeg2_q   <= 1'b1;
		end else if (step) begin
			window_q  <= window_n;
			fill_q    <= fill_n;
			phase_q   <= phase_n;
			offset_q  <= offset_n;
			hdr_len_q <= hdr_len_n;
			pkt_len_q <= pkt_len_n;
			id_q      <= id_n;
			len_hi_q  <= len_hi_n;
			stuff_q   <= stuff_n;
			mpeg2_q   <= mpeg2_n;
		end
	end

	assign emit = (fill_q == 2'd3);

	always_comb begin
		logic [OW-1:0]  pos;
		logic           known;
		logic           haslen;
		logic           bad;
		logic [OW-1:0]  total;
		logic [OW-1:0]  end_len;
		logic [OW:0]    next_off;

		window_n  = {window_q[15:0], data_byte};
		fill_n    = fill_q;
		phase_n   = phase_q;
		offset_n  = offset_q;
		hdr_len_n = hdr_len_q;
		pkt_len_n = pkt_len_q;
		id_n      = id_q;
		len_hi_n  = len_hi_q;
		stuff_n   = stuff_q;
		mpeg2_n   = mpeg2_q;
		pos       = offset_q + OW'(4);
		known     = 1'b0;
		haslen    = 1'b0;
		bad       = 1'b0;
		total     = '0;
		end_len   = '0;
		next_off  = '0;

		res                 = '0;
		res.out_byte        = window_q[23:16];
		res.byte_kind       = psd_pkg::KIND_SKIP;

		if (!emit) begin
			fill_n = fill_q + 2'd1;
		end else begin
			if (phase_q == psd_pkg::PH_SEARCH) begin
				if (window_q == 24'h000001) begin
					res.packet_first = 1'b1;
					id_n      = data_byte;
					offset_n  = '0;
					hdr_len_n = '0;
					pkt_len_n = '0;
					len_hi_n  = '0;
					stuff_n   = '0;
					if (data_byte <= psd_pkg::ID_REJECT_MAX) begin
						hdr_len_n = OW'(4);
						phase_n   = psd_pkg::PH_REJECT;
					end else if (data_byte == psd_pkg::ID_PACK) begin
						phase_n = psd_pkg::PH_PACK;
					end else if (data_byte == psd_pkg::ID_SYSTEM) begin
						phase_n = psd_pkg::PH_SYS;
					end else if (data_byte == psd_pkg::ID_PADDING ||
						data_byte == psd_pkg::ID_PRIVATE2) begin
						hdr_len_n = OW'(6);
						phase_n   = psd_pkg::PH_DONE;
					end else if (data_byte == psd_pkg::ID_PRIVATE1 ||
						(data_byte >= psd_pkg::ID_AV_FIRST &&
						data_byte <= psd_pkg::ID_AV_LAST)) begin
						phase_n = psd_pkg::PH_PES;
					end else begin
						hdr_len_n = OW'(4);
						phase_n   = psd_pkg::PH_DONE;
					end
				end
			end else begin
				offset_n = offset_q + OW'(1);
				if (pos == OW'(4))
					len_hi_n = data_byte;
				if (pos == OW'(5))
					pkt_len_n = {len_hi_q, data_byte};
				unique case (phase_q)
					psd_pkg::PH_PACK: begin
						if (pos == OW'(4)) begin
							if (data_byte[7:6] == psd_pkg::TOP_MPEG1) begin
								mpeg2_n = 1'b1;
								phase_n = psd_pkg::PH_PACKSTUFF;
							end else begin
								mpeg2_n   = 1'b0;
								hdr_len_n = OW'(12);
								phase_n   = psd_pkg::PH_DONE;
							end
						end
					end
					psd_pkg::PH_PACKSTUFF: begin
						if (pos == OW'(13)) begin
							hdr_len_n = OW'(14) + OW'(data_byte[2:0]);
							phase_n   = psd_pkg::PH_DONE;
						end
					end
					psd_pkg::PH_SYS: begin
						if (pos == OW'(5)) begin
							hdr_len_n = OW'(6) + OW'({len_hi_q, data_byte});
							phase_n   = psd_pkg::PH_DONE;
						end
					end
					psd_pkg::PH_PES: begin
						if (pos >= OW'(6)) begin
							case (data_byte[7:6])
								psd_pkg::TOP_STUFF: begin
									if (stuff_q >= STUFF_W'(MAX_STUFFING)) begin
										hdr_len_n = pos + OW'(1);
										phase_n   = psd_pkg::PH_REJECT;
									end else begin
										stuff_n = stuff_q + STUFF_W'(1);
									end
								end
								psd_pkg::TOP_MPEG2: begin
									mpeg2_n = 1'b1;
									phase_n = psd_pkg::PH_M2SKIP;
								end
								psd_pkg::TOP_MPEG1: begin
									mpeg2_n = 1'b0;
									phase_n = psd_pkg::PH_M1SKIP;
								end
								default: begin
									mpeg2_n   = 1'b0;
									hdr_len_n = mpeg1_hdr_len(pos, data_byte);
									phase_n   = psd_pkg::PH_DONE;
								end
							endcase
						end
					end
					psd_pkg::PH_M2SKIP: phase_n = psd_pkg::PH_M2LEN;
					psd_pkg::PH_M2LEN: begin
						hdr_len_n = pos + OW'(1) + OW'(data_byte);
						phase_n   = psd_pkg::PH_DONE;
					end
					psd_pkg::PH_M1SKIP: phase_n = psd_pkg::PH_M1FLAGS;
					psd_pkg::PH_M1FLAGS: begin
						hdr_len_n = mpeg1_hdr_len(pos, data_byte);
						phase_n   = psd_pkg::PH_DONE;
					end
					default: ;
				endcase
			end

			if (phase_n != psd_pkg::PH_SEARCH) begin
				known  = (phase_n == psd_pkg::PH_DONE) || (phase_n == psd_pkg::PH_REJECT);
				haslen = (id_n >= psd_pkg::ID_PRIVATE1) && (id_n <= psd_pkg::ID_AV_LAST);
				res.pkt_id    = id_n;
				res.byte_kind = (known && offset_n >= hdr_len_n) ?
					psd_pkg::KIND_PAYLOAD : psd_pkg::KIND_HEADER;
				if (known) begin
					total    = haslen ? (OW'(6) + OW'(pkt_len_n)) : hdr_len_n;
					bad      = (phase_n == psd_pkg::PH_REJECT) ||
						(haslen && total < hdr_len_n);
					end_len  = bad ? hdr_len_n : total;
					next_off = {1'b0, offset_n} + (OW+1)'(1);
					if (next_off >= {1'b0, end_len}) begin
						res.packet_last     = 1'b1;
						res.packet_rejected = bad;
						phase_n             = psd_pkg::PH_SEARCH;
					end
				end
			end
			res.is_mpeg2 = mpeg2_n;
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for pes_stream_deframer_unit: streams program/PES bytes in bursts, predicts
// the labelled byte for each transaction and checks every result field in order.
// Depends on psd_pkg and the deframer RTL.
module tb_top;
	import psd_pkg::*;

	localparam int MAX_STUFF = MAX_STUFFING_DEFAULT;
	localparam int ITEMS     = 1700;

	localparam logic [7:0] ID_END_CODE = 8'hB9;
	localparam logic [7:0] ID_MAP      = 8'hBC;
	localparam logic [7:0] ID_EXT_LOW  = 8'hF0;

	localparam logic [7:0] OPENING [25] = '{
		8'h00, 8'hFF,
		8'h00, 8'h00, 8'h01, ID_REJECT_MAX,
		8'h00, 8'h00, 8'h01, ID_END_CODE,
		8'h00, 8'h00, 8'h01, ID_PADDING, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h01, ID_AV_FIRST, 8'h00, 8'h00, {TOP_MPEG2, 6'h00}, 8'h00, 8'h00
	};

	typedef enum int {
		PK_PACK2, PK_PACK1, PK_SYS, PK_PAD, PK_PES2, PK_PES1BUF, PK_PES1,
		PK_STUFFED, PK_SHORT, PK_END, PK_BADID, PK_NOISE, PK_BROKEN
	} pkt_sort_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        m_tlast;

	logic [7:0]  stream_q [$];
	psd_result_t label_q [$];
	int          mismatches = 0;

	logic [23:0] win = '0;
	logic [1:0]  win_fill = '0;
	psd_phase_t  phase = PH_SEARCH;
	logic [16:0] offs = '0;
	logic [16:0] hdr_len = '0;
	logic [16:0] pay_len = '0;
	logic [7:0]  cur_id = '0;
	logic [7:0]  len_hi = '0;
	logic [5:0]  stuff_cnt = '0;
	logic        m2 = 1'b1;

	int          gap_left = 0;
	int          burst_left = 0;
	logic [31:0] rx_mask = '1;
	logic [4:0]  rx_pos = '0;

	pes_stream_deframer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [16:0] m1_hdr_len(input int pos, input logic [7:0] b);
		case (b[5:4])
		M1_PTS_DTS: return 17'(pos + 10);
		M1_PTS:     return 17'(pos + 5);
		default:    return 17'(pos + 1);
		endcase
	endfunction

	task automatic deframe_byte(input logic [7:0] b);
		logic [7:0]  w0, w1, w2;
		psd_result_t r;
		int          pos, total, stop;
		bit          known, haslen, bad;
		if (win_fill < 3) begin
			win = {win[15:0], b};
			win_fill++;
			return;
		end
		{w0, w1, w2} = win;
		r = '0;
		r.byte_kind = KIND_SKIP;
		if (phase == PH_SEARCH) begin
			if (w0 == 8'h00 && w1 == 8'h00 && w2 == 8'h01) begin
				cur_id = b;
				offs = '0;
				hdr_len = '0;
				pay_len = '0;
				len_hi = '0;
				stuff_cnt = '0;
				r.packet_first = 1'b1;
				if (b <= ID_REJECT_MAX) begin
					hdr_len = 17'(4);
					phase = PH_REJECT;
				end else if (b == ID_PACK)
					phase = PH_PACK;
				else if (b == ID_SYSTEM)
					phase = PH_SYS;
				else if (b == ID_PADDING || b == ID_PRIVATE2) begin
					hdr_len = 17'(6);
					phase = PH_DONE;
				end else if (b == ID_PRIVATE1 || (b >= ID_AV_FIRST && b <= ID_AV_LAST))
					phase = PH_PES;
				else begin
					hdr_len = 17'(4);
					phase = PH_DONE;
				end
			end
		end else begin
			offs++;
			pos = offs + 3;
			if (pos == 4)
				len_hi = b;
			if (pos == 5)
				pay_len = 17'({len_hi, b});
			case (phase)
			PH_PACK: if (pos == 4) begin
				if (b[7:6] == TOP_MPEG1) begin
					m2 = 1'b1;
					phase = PH_PACKSTUFF;
				end else begin
					m2 = 1'b0;
					hdr_len = 17'(12);
					phase = PH_DONE;
				end
			end
			PH_PACKSTUFF: if (pos == 13) begin
				hdr_len = 17'(14 + b[2:0]);
				phase = PH_DONE;
			end
			PH_SYS: if (pos == 5) begin
				hdr_len = 17'(6 + pay_len);
				phase = PH_DONE;
			end
			PH_PES: if (pos >= 6) begin
				case (b[7:6])
				TOP_STUFF: begin
					if (stuff_cnt >= MAX_STUFF) begin
						hdr_len = 17'(pos + 1);
						phase = PH_REJECT;
					end else
						stuff_cnt++;
				end
				TOP_MPEG2: begin
					m2 = 1'b1;
					phase = PH_M2SKIP;
				end
				TOP_MPEG1: begin
					m2 = 1'b0;
					phase = PH_M1SKIP;
				end
				default: begin
					m2 = 1'b0;
					hdr_len = m1_hdr_len(pos, b);
					phase = PH_DONE;
				end
				endcase
			end
			PH_M2SKIP: phase = PH_M2LEN;
			PH_M2LEN: begin
				hdr_len = 17'(pos + 1 + b);
				phase = PH_DONE;
			end
			PH_M1SKIP: phase = PH_M1FLAGS;
			PH_M1FLAGS: begin
				hdr_len = m1_hdr_len(pos, b);
				phase = PH_DONE;
			end
			default: ;
			endcase
		end
		if (phase != PH_SEARCH) begin
			known = (phase == PH_DONE || phase == PH_REJECT);
			r.pkt_id = cur_id;
			r.byte_kind = (known && offs >= hdr_len) ? KIND_PAYLOAD : KIND_HEADER;
			if (known) begin
				haslen = cur_id >= ID_PRIVATE1 && cur_id <= ID_AV_LAST;
				total = haslen ? 6 + pay_len : hdr_len;
				bad = phase == PH_REJECT || (haslen && total < hdr_len);
				stop = bad ? hdr_len : total;
				if (offs + 1 >= stop) begin
					r.packet_last = 1'b1;
					r.packet_rejected = bad;
					phase = PH_SEARCH;
				end
			end
		end
		r.out_byte = w0;
		r.is_mpeg2 = m2;
		label_q.push_back(r);
		win = {win[15:0], b};
	endtask

	task automatic add_packet(input pkt_sort_t sort);
		logic [7:0]  hdr [$];
		logic [7:0]  id, flags;
		logic [15:0] plen;
		int          stuff, pay;
		if (sort == PK_NOISE) begin
			repeat ($urandom_range(1, 12))
				stream_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			return;
		end
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'h01);
		case (sort)
		PK_PACK2: begin
			id = ID_PACK;
			stuff = $urandom_range(0, 7);
			hdr.push_back({TOP_MPEG1, 6'($urandom)});
			repeat (8) hdr.push_back(8'($urandom));
			hdr.push_back({5'($urandom), 3'(stuff)});
			repeat (stuff) hdr.push_back(8'hFF);
		end
		PK_PACK1: begin
			id = ID_PACK;
			flags = 8'($urandom);
			if (flags[7:6] == TOP_MPEG1)
				flags[7] = 1'b1;
			hdr.push_back(flags);
			repeat (7) hdr.push_back(8'($urandom));
		end
		PK_SYS, PK_PAD: begin
			if (sort == PK_SYS)
				id = ID_SYSTEM;
			else
				id = $urandom_range(0, 1) ? ID_PADDING : ID_PRIVATE2;
			pay = $urandom_range(0, 24);
			hdr.push_back(8'h00);
			hdr.push_back(8'(pay));
			repeat (pay) hdr.push_back(8'($urandom));
		end
		PK_END: begin
			case ($urandom_range(0, 2))
			0:       id = ID_END_CODE;
			1:       id = ID_MAP;
			default: id = 8'($urandom_range(ID_EXT_LOW, 8'hFF));
			endcase
		end
		PK_BADID: begin
			id = 8'($urandom_range(0, ID_REJECT_MAX));
			repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom));
		end
		PK_BROKEN: begin
			id = 8'($urandom);
			hdr.push_back(8'h00);
			hdr.push_back(8'($urandom_range(0, 8)));
			repeat ($urandom_range(0, 8)) hdr.push_back(8'($urandom));
		end
		default: begin
			id = ($urandom_range(0, 3) == 0) ? ID_PRIVATE1
				: 8'($urandom_range(ID_AV_FIRST, ID_AV_LAST));
			stuff = (sort == PK_STUFFED) ? $urandom_range(MAX_STUFF - 1, MAX_STUFF + 2)
				: $urandom_range(0, 3);
			repeat (stuff) hdr.push_back({TOP_STUFF, 6'($urandom)});
			if (sort == PK_PES1BUF) begin
				hdr.push_back({TOP_MPEG1, 6'($urandom)});
				hdr.push_back(8'($urandom));
			end
			if (sort == PK_PES1 || sort == PK_PES1BUF) begin
				flags = {2'b00, 2'($urandom), 4'($urandom)};
				hdr.push_back(flags);
				repeat ((flags[5:4] == M1_PTS_DTS) ? 9 : (flags[5:4] == M1_PTS) ? 4 : 0)
					hdr.push_back(8'($urandom));
			end else begin
				hdr.push_back({TOP_MPEG2, 6'($urandom)});
				hdr.push_back(8'($urandom));
				pay = $urandom_range(0, 10);
				hdr.push_back(8'(pay));
				repeat (pay) hdr.push_back(8'($urandom));
			end
			pay = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 400) : $urandom_range(0, 24);
			plen = (sort == PK_SHORT) ? 16'($urandom_range(0, hdr.size() - 1))
				: 16'(hdr.size() + pay);
			hdr.push_front(plen[7:0]);
			hdr.push_front(plen[15:8]);
			if (sort != PK_SHORT)
				repeat (pay) hdr.push_back(8'($urandom));
		end
		endcase
		stream_q.push_back(id);
		foreach (hdr[i])
			stream_q.push_back(hdr[i]);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 20)
			$display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (stream_q.size() != 0 || s_tvalid || label_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= stream_q.pop_front();
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 16);
						gap_left = $urandom_range(1, 5);
					end else
						burst_left--;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (rx_pos == 0) begin
			case ($urandom_range(0, 3))
			0:       rx_mask = '1;
			1:       rx_mask = $urandom;
			2:       rx_mask = $urandom | $urandom;
			default: rx_mask = $urandom & $urandom;
			endcase
			if (rx_mask == 0)
				rx_mask = '1;
		end
		m_tready <= rx_mask[rx_pos];
		rx_pos <= rx_pos + 1'b1;
	end

	always @(posedge clk) begin : result_check
		psd_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (label_q.size() == 0)
				report_mismatch("result with none pending", m_tdata, 0);
			else begin
				want = label_q.pop_front();
				if (m_tdata[7:0] != want.out_byte)
					report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
				if (m_tdata[15:8] != want.pkt_id)
					report_mismatch("pkt_id", m_tdata[15:8], want.pkt_id);
				if (m_tuser[1:0] != want.byte_kind)
					report_mismatch("byte_kind", m_tuser[1:0], want.byte_kind);
				if (m_tuser[2] != want.packet_first)
					report_mismatch("packet_first", m_tuser[2], want.packet_first);
				if (m_tuser[3] != want.packet_rejected)
					report_mismatch("packet_rejected", m_tuser[3], want.packet_rejected);
				if (m_tuser[4] != want.is_mpeg2)
					report_mismatch("is_mpeg2", m_tuser[4], want.is_mpeg2);
				if (m_tlast != want.packet_last)
					report_mismatch("packet_last", m_tlast, want.packet_last);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		foreach (OPENING[i])
			stream_q.push_back(OPENING[i]);
		wait_drained();
		for (int k = 0; k <= PK_BROKEN; k++)
			add_packet(pkt_sort_t'(k));
		while (stream_q.size() < ITEMS / 2)
			add_packet(pkt_sort_t'($urandom_range(0, PK_BROKEN)));
		wait_drained();
		while (stream_q.size() < ITEMS / 2)
			add_packet(pkt_sort_t'($urandom_range(0, PK_BROKEN)));
		wait_drained();
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
design/psd_pkg.sv
design/psd_parser.sv
design/pes_stream_deframer_unit.sv
test/tb_top.sv
